@@ design/fths_pkg.sv @@
// shared types, codes and defaults for the face track hold smoother
package fths_pkg;

	localparam int DEF_COORD_BITS = 12;
	localparam int DEF_TIME_BITS  = 40;

	localparam logic FUNC_CAND = 1'b0;
	localparam logic FUNC_EOF  = 1'b1;

	localparam logic [1:0] SRC_NONE  = 2'd0;
	localparam logic [1:0] SRC_HELD  = 2'd1;
	localparam logic [1:0] SRC_FRESH = 2'd2;

	localparam logic [6:0] CONF_FRESH = 7'd100;
	localparam logic [6:0] CONF_NONE  = 7'd0;

	localparam logic [1:0] CFG_DETECTOR_READY = 2'd0;
	localparam logic [1:0] CFG_MAX_MISSES     = 2'd1;
	localparam logic [1:0] CFG_MAX_HOLD_MS    = 2'd2;
	localparam logic [1:0] CFG_HELD_CONF      = 2'd3;

	localparam logic [2:0]  RST_MAX_MISSES  = 3'd3;
	localparam logic [15:0] RST_MAX_HOLD_MS = 16'd200;
	localparam logic [6:0]  RST_HELD_CONF   = 7'd45;

	typedef struct packed {
		logic        detector_ready;
		logic [2:0]  max_held_misses;
		logic [15:0] max_hold_ms;
		logic [6:0]  held_confidence_pct;
	} cfg_t;

	typedef struct packed {
		logic cand;
		logic frame_end;
	} step_t;

endpackage

@@ design/fths_best.sv @@
// best candidate tracker for the current frame
module fths_best #(
	parameter int COORD_BITS = fths_pkg::DEF_COORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fths_pkg::step_t         step,
	input  logic [COORD_BITS-1:0]   cand_x,
	input  logic [COORD_BITS-1:0]   cand_y,
	input  logic [COORD_BITS-1:0]   cand_w,
	input  logic [COORD_BITS-1:0]   cand_h,
	input  logic [2*COORD_BITS-1:0] cand_area,
	output logic                    found,
	output logic [COORD_BITS-1:0]   best_x,
	output logic [COORD_BITS-1:0]   best_y,
	output logic [COORD_BITS-1:0]   best_w,
	output logic [COORD_BITS-1:0]   best_h
);
	import fths_pkg::*;

	logic                    have_q;
	logic [COORD_BITS-1:0]   x_q, y_q, w_q, h_q;
	logic [2*COORD_BITS-1:0] area_q;
	logic                    beats;

	always_comb begin
		beats = 1'b0;
		if (cand_area != area_q) begin
			beats = cand_area > area_q;
		end else if (cand_y != y_q) begin
			beats = cand_y < y_q;
		end else begin
			beats = cand_x < x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (step.frame_end) begin
			have_q <= 1'b0;
		end else if (step.cand) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step.cand && (!have_q || beats)) begin
			x_q    <= cand_x;
			y_q    <= cand_y;
			w_q    <= cand_w;
			h_q    <= cand_h;
			area_q <= cand_area;
		end
	end

	assign found  = have_q;
	assign best_x = x_q;
	assign best_y = y_q;
	assign best_w = w_q;
	assign best_h = h_q;

endmodule

@@ design/fths_hold.sv @@
// frame end hold logic, averaging and result register
module fths_hold #(
	parameter int COORD_BITS = fths_pkg::DEF_COORD_BITS,
	parameter int TIME_BITS  = fths_pkg::DEF_TIME_BITS,
	parameter int OUT_W      = ((7 + 4*COORD_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fths_pkg::step_t       step,
	input  fths_pkg::cfg_t        cfg,
	input  logic                  found,
	input  logic [COORD_BITS-1:0] best_x,
	input  logic [COORD_BITS-1:0] best_y,
	input  logic [COORD_BITS-1:0] best_w,
	input  logic [COORD_BITS-1:0] best_h,
	input  logic                  usable,
	input  logic [TIME_BITS-1:0]  now,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_W-1:0]      m_tdata,
	output logic [2:0]            m_tuser,
	output logic                  out_free
);
	import fths_pkg::*;

	localparam int RECT_BITS = 4*COORD_BITS;

	logic                 holding_q;
	logic [RECT_BITS-1:0] held_q;
	logic [2:0]           miss_q;
	logic [TIME_BITS-1:0] last_q;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;
	logic [2:0]           out_user_q;

	logic [RECT_BITS-1:0] best_rect, avg_rect, sel_rect, res_rect;
	logic [3:0]           misses;
	logic [TIME_BITS-1:0] elapsed;
	logic                 in_window;
	logic [1:0]           res_src;
	logic [6:0]           res_conf;

	function automatic logic [COORD_BITS-1:0] avg_up(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic [COORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b} + (COORD_BITS+1)'(1);
		return s[COORD_BITS:1];
	endfunction

	assign best_rect = {best_h, best_w, best_y, best_x};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			avg_rect[i*COORD_BITS +: COORD_BITS] =
				avg_up(held_q[i*COORD_BITS +: COORD_BITS],
					best_rect[i*COORD_BITS +: COORD_BITS]);
		end
	end

	assign sel_rect  = holding_q ? avg_rect : best_rect;
	assign misses    = {1'b0, miss_q} + 4'd1;
	assign elapsed   = now - last_q;
	assign in_window = holding_q && (misses <= {1'b0, cfg.max_held_misses}) &&
		(now >= last_q) && (elapsed <= TIME_BITS'(cfg.max_hold_ms));

	always_comb begin
		res_src  = SRC_NONE;
		res_conf = CONF_NONE;
		res_rect = '0;
		if (cfg.detector_ready && usable) begin
			if (found) begin
				res_src  = SRC_FRESH;
				res_conf = CONF_FRESH;
				res_rect = sel_rect;
			end else if (in_window) begin
				res_src  = SRC_HELD;
				res_conf = cfg.held_confidence_pct;
				res_rect = held_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			miss_q    <= '0;
		end else if (step.frame_end && cfg.detector_ready && usable) begin
			if (found) begin
				holding_q <= 1'b1;
				miss_q    <= '0;
			end else if (in_window) begin
				miss_q <= misses[2:0];
			end else begin
				holding_q <= 1'b0;
				miss_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.frame_end && cfg.detector_ready && usable && found) begin
			held_q <= sel_rect;
			last_q <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.frame_end) begin
			out_data_q <= OUT_W'({res_rect, res_conf});
			out_user_q <= {res_src, res_src != SRC_NONE};
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ design/face_track_hold_smoother_core.sv @@
// top level of the face track hold smoother
// path: an accepted frame end request sits in the input register, then loads the result register that drives m_tvalid
// throughput: one request per cycle; the input waits only while a frame end sits in the
// input register and the result register holds an untaken result
// reset: arst_n clears the hold, the frame's best candidate, all valid flags and
// loads the register defaults (detector not ready, 3 misses, 200 ms, 45 percent)
module face_track_hold_smoother_core #(
	parameter int COORD_BITS = fths_pkg::DEF_COORD_BITS,
	parameter int TIME_BITS  = fths_pkg::DEF_TIME_BITS,
	parameter int IN_W  = ((4*COORD_BITS + 1 + TIME_BITS + 7) / 8) * 8,
	parameter int OUT_W = ((7 + 4*COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// face_x, face_y, face_w, face_h, frame_usable, time_ms, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	// func
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// confidence_pct, out_x, out_y, out_w, out_h, zero fill
	output logic [OUT_W-1:0] m_tdata,
	// face_found, source
	output logic [2:0]       m_tuser,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import fths_pkg::*;

	localparam int C = COORD_BITS;

	cfg_t cfg_q;

	logic                 valid_s1;
	logic                 func_s1;
	logic [C-1:0]         x_s1, y_s1, w_s1, h_s1;
	logic [2*C-1:0]       area_s1;
	logic                 usable_s1;
	logic [TIME_BITS-1:0] time_s1;

	logic [2*C-1:0] area_in;
	logic           adv, out_free, found;
	logic [C-1:0]   best_x, best_y, best_w, best_h;
	step_t          step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detector_ready      <= 1'b0;
			cfg_q.max_held_misses     <= RST_MAX_MISSES;
			cfg_q.max_hold_ms         <= RST_MAX_HOLD_MS;
			cfg_q.held_confidence_pct <= RST_HELD_CONF;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DETECTOR_READY: cfg_q.detector_ready <= cfg_data[0];
				CFG_MAX_MISSES:     cfg_q.max_held_misses <= cfg_data[2:0];
				CFG_MAX_HOLD_MS:    cfg_q.max_hold_ms <= cfg_data;
				CFG_HELD_CONF:      cfg_q.held_confidence_pct <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign area_in = {{C{1'b0}}, s_tdata[2*C +: C]} * {{C{1'b0}}, s_tdata[3*C +: C]};

	assign adv      = valid_s1 && ((func_s1 == FUNC_CAND) || out_free);
	assign s_tready = !valid_s1 || adv;

	assign step.cand      = valid_s1 && (func_s1 == FUNC_CAND);
	assign step.frame_end = valid_s1 && (func_s1 == FUNC_EOF) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= s_tuser;
			x_s1      <= s_tdata[0 +: C];
			y_s1      <= s_tdata[C +: C];
			w_s1      <= s_tdata[2*C +: C];
			h_s1      <= s_tdata[3*C +: C];
			area_s1   <= area_in;
			usable_s1 <= s_tdata[4*C];
			time_s1   <= s_tdata[4*C+1 +: TIME_BITS];
		end
	end

	fths_best #(
		.COORD_BITS(COORD_BITS)
	) u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cand_x   (x_s1),
		.cand_y   (y_s1),
		.cand_w   (w_s1),
		.cand_h   (h_s1),
		.cand_area(area_s1),
		.found    (found),
		.best_x   (best_x),
		.best_y   (best_y),
		.best_w   (best_w),
		.best_h   (best_h)
	);

	fths_hold #(
		.COORD_BITS(COORD_BITS),
		.TIME_BITS (TIME_BITS),
		.OUT_W     (OUT_W)
	) u_hold (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.cfg     (cfg_q),
		.found   (found),
		.best_x  (best_x),
		.best_y  (best_y),
		.best_w  (best_w),
		.best_h  (best_h),
		.usable  (usable_s1),
		.now     (time_s1),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.out_free(out_free)
	);

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == SRC_NONE && m_tdata == '0)
		else $error("no-face result carries data");

	a_found_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == SRC_HELD || m_tuser[2:1] == SRC_FRESH)
		else $error("face result without source");

	a_fresh_conf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] == SRC_FRESH |-> m_tdata[6:0] == CONF_FRESH)
		else $error("fresh result with wrong confidence");

	a_stall_only_eof: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && func_s1 == FUNC_EOF && m_tvalid && !m_tready)
		else $error("input stalled without a blocked frame end");

	a_eof_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		step.frame_end |=> m_tvalid)
		else $error("frame end did not produce a result");

endmodule

@@ sim/tb_top.sv @@
// testbench for the face track hold smoother: predicts every frame result and checks the stream
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fths_pkg::*;

	localparam int CW           = DEF_COORD_BITS;
	localparam int TW           = DEF_TIME_BITS;
	localparam int IN_W         = ((4*CW + 1 + TW + 7) / 8) * 8;
	localparam int OUT_W        = ((7 + 4*CW + 7) / 8) * 8;
	localparam int RUN_LIMIT    = 400000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] w;
		logic [CW-1:0] h;
	} box_t;

	typedef struct packed {
		logic       found;
		logic [1:0] src;
		logic [6:0] conf;
		box_t       box;
	} report_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tready  = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [15:0]      cfg_data  = '0;
	wire              s_tready;
	wire              m_tvalid;
	wire [OUT_W-1:0]  m_tdata;
	wire [2:0]        m_tuser;
	wire              cfg_ready;

	// predictor state
	cfg_t             trk_cfg;
	logic             trk_have_best;
	box_t             trk_best;
	logic             trk_holding;
	box_t             trk_held;
	logic [2:0]       trk_misses;
	logic [TW-1:0]    trk_last_ms;

	report_t          frame_results[$];
	report_t          want;
	int               errors     = 0;
	int               cycles     = 0;
	int               stall_left = 0;
	logic             src_idle   = 1'b1;
	logic             sink_stall = 1'b1;
	logic [TW-1:0]    stream_ms  = '0;

	face_track_hold_smoother_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (sink_stall && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic box_beats(box_t c, box_t b);
		logic [2*CW-1:0] ac;
		logic [2*CW-1:0] ab;
		ac = c.w * c.h;
		ab = b.w * b.h;
		if (ac != ab)
			return ac > ab;
		if (c.y != b.y)
			return c.y < b.y;
		return c.x < b.x;
	endfunction

	function automatic logic [CW-1:0] round_mean(logic [CW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b} + (CW+1)'(1);
		return s[CW:1];
	endfunction

	function automatic logic [IN_W-1:0] frame_word(box_t b, logic usable, logic [TW-1:0] t);
		return {{(IN_W - 4*CW - 1 - TW){1'b0}}, t, usable, b.h, b.w, b.y, b.x};
	endfunction

	function automatic box_t rand_box();
		box_t b;
		if ($urandom_range(0, 1) != 0) begin
			// small values so that areas and corners tie often
			b.x = CW'($urandom_range(0, 3));
			b.y = CW'($urandom_range(0, 3));
			b.w = CW'($urandom_range(0, 7));
			b.h = CW'($urandom_range(0, 7));
		end else begin
			b.x = CW'($urandom);
			b.y = CW'($urandom);
			b.w = CW'($urandom);
			b.h = CW'($urandom);
		end
		return b;
	endfunction

	function automatic logic [TW-1:0] rand_time();
		return TW'({$urandom, $urandom});
	endfunction

	task automatic track_step(logic func, logic [IN_W-1:0] d);
		box_t          c;
		box_t          sel;
		report_t       r;
		logic [TW-1:0] now;
		logic [3:0]    misses;
		logic          found;
		c.x = d[0 +: CW];
		c.y = d[CW +: CW];
		c.w = d[2*CW +: CW];
		c.h = d[3*CW +: CW];
		if (func == FUNC_CAND) begin
			if (!trk_have_best || box_beats(c, trk_best)) begin
				trk_best = c;
				trk_have_best = 1'b1;
			end
		end else begin
			found = trk_have_best;
			sel = trk_best;
			now = d[4*CW+1 +: TW];
			trk_have_best = 1'b0;
			trk_best = '0;
			r.found = 1'b0;
			r.src = SRC_NONE;
			r.conf = CONF_NONE;
			r.box = '0;
			if (trk_cfg.detector_ready && d[4*CW]) begin
				if (found) begin
					if (trk_holding) begin
						sel.x = round_mean(trk_held.x, sel.x);
						sel.y = round_mean(trk_held.y, sel.y);
						sel.w = round_mean(trk_held.w, sel.w);
						sel.h = round_mean(trk_held.h, sel.h);
					end
					trk_held = sel;
					trk_last_ms = now;
					trk_holding = 1'b1;
					trk_misses = '0;
					r.found = 1'b1;
					r.src = SRC_FRESH;
					r.conf = CONF_FRESH;
					r.box = sel;
				end else begin
					misses = {1'b0, trk_misses} + 4'd1;
					if (trk_holding && misses <= {1'b0, trk_cfg.max_held_misses} &&
							now >= trk_last_ms &&
							now - trk_last_ms <= TW'(trk_cfg.max_hold_ms)) begin
						trk_misses = misses[2:0];
						r.found = 1'b1;
						r.src = SRC_HELD;
						r.conf = trk_cfg.held_confidence_pct;
						r.box = trk_held;
					end else begin
						trk_holding = 1'b0;
						trk_misses = '0;
					end
				end
			end
			frame_results.push_back(r);
		end
	endtask

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_results.size() == 0) begin
				$error("result with no frame end pending");
				errors++;
			end else begin
				want = frame_results.pop_front();
				check_field("face_found", want.found, m_tuser[0]);
				check_field("source", want.src, m_tuser[2:1]);
				check_field("confidence_pct", want.conf, m_tdata[6:0]);
				check_field("out_x", want.box.x, m_tdata[7 +: CW]);
				check_field("out_y", want.box.y, m_tdata[7+CW +: CW]);
				check_field("out_w", want.box.w, m_tdata[7+2*CW +: CW]);
				check_field("out_h", want.box.h, m_tdata[7+3*CW +: CW]);
			end
		end
	end

	// valid stays high on return so back-to-back requests need no gap
	task automatic send_item(logic func, logic [IN_W-1:0] d);
		int gap;
		if (src_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		track_step(func, d);
	endtask

	task automatic send_cand(int x, int y, int w, int h);
		box_t b;
		b.x = CW'(x);
		b.y = CW'(y);
		b.w = CW'(w);
		b.h = CW'(h);
		send_item(FUNC_CAND, frame_word(b, 1'b0, '0));
	endtask

	task automatic send_eof(logic usable, logic [TW-1:0] t);
		send_item(FUNC_EOF, frame_word('0, usable, t));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DETECTOR_READY: trk_cfg.detector_ready = val[0];
			CFG_MAX_MISSES:     trk_cfg.max_held_misses = val[2:0];
			CFG_MAX_HOLD_MS:    trk_cfg.max_hold_ms = val;
			CFG_HELD_CONF:      trk_cfg.held_confidence_pct = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic ready, logic [2:0] misses, logic [15:0] hold_ms,
			logic [6:0] conf);
		write_reg(CFG_DETECTOR_READY, {15'b0, ready});
		write_reg(CFG_MAX_MISSES, {13'b0, misses});
		write_reg(CFG_MAX_HOLD_MS, hold_ms);
		write_reg(CFG_HELD_CONF, {9'b0, conf});
		cfg_valid <= 1'b0;
	endtask

	// wait until every frame end has reported and the pipeline is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (frame_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_cand(1, 2, 3, 4);
		send_eof(1'b1, 40'd100);
		drain();
		set_config(1'b1, RST_MAX_MISSES, RST_MAX_HOLD_MS, RST_HELD_CONF);
	endtask

	task automatic test_candidate_selection();
		send_cand(10, 20, 30, 40);
		send_cand(5, 5, 40, 30);
		send_cand(4, 5, 30, 40);
		send_cand(0, 0, 0, 0);
		send_eof(1'b1, 40'd1000);
		send_cand(4095, 4095, 4095, 4095);
		send_cand(0, 0, 4095, 4095);
		send_eof(1'b1, 40'd1010);
	endtask

	task automatic test_hold_window();
		send_eof(1'b1, 40'd1050);
		send_eof(1'b0, 40'd1060);
		send_eof(1'b1, 40'd1100);
		send_eof(1'b1, 40'd1150);
		send_eof(1'b1, 40'd1160);
		// fresh after the hold dropped, then time going backwards
		send_cand(7, 9, 11, 13);
		send_eof(1'b1, 40'd2000);
		send_eof(1'b1, 40'd1999);
		// elapsed time one past the window
		send_cand(100, 200, 300, 400);
		send_eof(1'b1, 40'd5000);
		send_eof(1'b1, 40'd5201);
		send_cand(1, 1, 1, 1);
		send_eof(1'b1, '1);
		send_eof(1'b1, '0);
	endtask

	task automatic test_config_extremes();
		drain();
		set_config(1'b1, 3'd0, 16'd0, 7'd0);
		send_cand(3, 3, 3, 3);
		send_eof(1'b1, 40'd10);
		send_eof(1'b1, 40'd10);
		drain();
		set_config(1'b1, 3'd7, 16'd0, 7'd127);
		send_cand(8, 8, 8, 8);
		send_eof(1'b1, 40'd20);
		send_eof(1'b1, 40'd20);
		send_eof(1'b1, 40'd21);
		drain();
		set_config(1'b1, 3'd6, 16'd65535, 7'd100);
		send_cand(50, 60, 70, 80);
		send_eof(1'b1, 40'd30);
		send_eof(1'b1, 40'd65565);
		send_eof(1'b1, 40'd65566);
		drain();
		set_config(1'b0, 3'd6, 16'd65535, 7'd100);
		send_cand(50, 60, 70, 80);
		send_eof(1'b1, 40'd70000);
	endtask

	task automatic run_frames(int n_items);
		int sent;
		int ncand;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 11) == 0) begin
				// stray frame end with arbitrary content
				send_item(FUNC_EOF,
					frame_word(rand_box(), 1'($urandom_range(0, 1)), rand_time()));
				sent++;
			end else begin
				ncand = $urandom_range(0, 4);
				repeat (ncand) begin
					send_item(FUNC_CAND,
						frame_word(rand_box(), 1'($urandom_range(0, 1)), rand_time()));
					sent++;
				end
				case ($urandom_range(0, 19))
					0:       stream_ms = stream_ms - $urandom_range(1, 50);
					1, 2:    stream_ms = stream_ms + $urandom_range(0, 70000);
					3:       stream_ms = rand_time();
					default: stream_ms = stream_ms + $urandom_range(0, 120);
				endcase
				send_item(FUNC_EOF,
					frame_word(rand_box(), $urandom_range(0, 9) != 0, stream_ms));
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 5; p++) begin
			drain();
			set_config($urandom_range(0, 5) != 0, 3'($urandom_range(0, 7)),
				16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) :
					$urandom_range(0, 300)),
				7'($urandom_range(0, 127)));
			run_frames(110);
		end
		// no idling on either side for the closing stretch
		src_idle = 1'b0;
		sink_stall = 1'b0;
		drain();
		set_config(1'b1, RST_MAX_MISSES, RST_MAX_HOLD_MS, RST_HELD_CONF);
		run_frames(90);
	endtask

	initial begin
		trk_cfg.detector_ready = 1'b0;
		trk_cfg.max_held_misses = RST_MAX_MISSES;
		trk_cfg.max_hold_ms = RST_MAX_HOLD_MS;
		trk_cfg.held_confidence_pct = RST_HELD_CONF;
		trk_have_best = 1'b0;
		trk_best = '0;
		trk_holding = 1'b0;
		trk_held = '0;
		trk_misses = '0;
		trk_last_ms = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_candidate_selection();
		test_hold_window();
		test_config_extremes();
		test_random_traffic();
		drain();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
